// ===== design/life_generation_stream_unit_assert.svh =====
// assertion macros for the life generation stream unit
`ifndef LIFE_GENERATION_STREAM_UNIT_ASSERT_SVH
`define LIFE_GENERATION_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LGS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lgs implication check failed");

// antecedent implies consequent in the next cycle
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lgs next-cycle check failed");

`else

`define LGS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/lgs_pkg.sv =====
// shared types and constants for the life generation stream unit
`default_nettype none

package lgs_pkg;

    localparam int POS_W     = 21;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int TRIP_W    = 3;
    localparam int WIN_W     = 9;
    localparam int WIN_COLS  = 2;
    localparam int CNT_W     = 4;

    localparam int MIN_DIM        = 3;
    localparam int RST_DIM        = 1024;
    localparam int DEF_MAX_LINE   = 1024;
    localparam int DEF_MAX_LINES  = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;

    // window bit layout: bit 3*col + row, row 0 upper, col 2 newest
    localparam logic [WIN_W-1:0] MASK_TOP    = 9'h049;
    localparam logic [WIN_W-1:0] MASK_BOTTOM = 9'h124;
    localparam logic [WIN_W-1:0] MASK_LEFT   = 9'h007;
    localparam logic [WIN_W-1:0] MASK_RIGHT  = 9'h1C0;
    localparam int               SELF_BIT    = 4;

    localparam logic [CNT_W-1:0] BIRTH_N    = 4'd3;
    localparam logic [CNT_W-1:0] SURVIVE_LO = 4'd2;
    localparam logic [CNT_W-1:0] SURVIVE_HI = 4'd3;

    typedef struct packed {
        logic             next_cell;
        logic             frame_end;
        logic [POS_W-1:0] live_total;
    } result_t;

endpackage

`default_nettype wire

// ===== design/life_generation_stream_unit.sv =====
// Streaming one-generation Life engine (birth on 3, survival on 2 or 3). Cells
// enter in scan order, one per item, and the engine takes one item per clock
// cycle while s_ready is high; the result for a cell leaves line_length+1 items
// after the cell, so after the last cell of a frame send line_length+1 flush
// items. Cells outside the grid count as dead; the frame_end result carries the
// live count of the input generation. After reset s_ready stays low while the
// two line memories are cleared one entry per cycle. After each write to the
// line length or line count s_ready stays low while a bit-serial divider
// recomputes the output line and column: a start step, 21 quotient bits at one
// per cycle, and a step to load the result.
`default_nettype none

`include "life_generation_stream_unit_assert.svh"

module life_generation_stream_unit #(
    parameter int MAX_LINE  = lgs_pkg::DEF_MAX_LINE,
    parameter int MAX_LINES = lgs_pkg::DEF_MAX_LINES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_cell_req,
    input  wire logic                            s_flush,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_next_cell,
    output logic                                 m_frame_end,
    output logic      [lgs_pkg::POS_W-1:0]       m_live_total,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]       cfg_wdata
);
    import lgs_pkg::*;

    localparam int LEN_W   = $clog2(MAX_LINE + 1);
    localparam int LINE_W  = $clog2(MAX_LINES + 1);
    localparam int ADDR_W  = $clog2(MAX_LINE);
    localparam int TOT_W   = LEN_W + LINE_W;
    localparam int CMP_W   = (POS_W + 1 > TOT_W) ? POS_W + 1 : TOT_W;
    localparam int LEN_RST = (RST_DIM > MAX_LINE) ? MAX_LINE : RST_DIM;
    localparam int LIN_RST = (RST_DIM > MAX_LINES) ? MAX_LINES : RST_DIM;

    // configuration and frame position state
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LINE_W-1:0] lines_reg, lines_next;
    logic [TOT_W-1:0]  total_reg;
    logic              div_pend_reg, div_pend_next;
    logic [LEN_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [POS_W-1:0]  opos_reg, opos_next;
    logic [LINE_W-1:0] oline_reg, oline_next;
    logic [ADDR_W-1:0] ocol_reg, ocol_next;
    logic [POS_W-1:0]  live_reg, live_next;

    logic [31:0]       cfg_val32;
    logic              col_wrap;
    logic [LEN_W-1:0]  col_e;
    logic [LINE_W-1:0] line_e;
    logic              cur;
    logic [POS_W-1:0]  live_inc;
    logic [TRIP_W-1:0] trip;
    logic [TRIP_W-1:0] win_q [WIN_COLS];
    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  win_m;
    logic [CNT_W-1:0]  nbr;
    logic              self_live;
    logic              next_cell;
    logic              emit;
    logic              last;
    logic [CMP_W-1:0]  pos_inc;
    logic              accept;
    logic              frame_done;
    logic              stall;
    logic [ADDR_W-1:0] raddr;
    logic              rd_upper;
    logic              rd_middle;
    logic              clearing;
    logic              div_busy;
    logic              div_done;
    logic [LINE_W-1:0] div_line;
    logic [ADDR_W-1:0] div_col;
    logic              res_ready;
    result_t           res;
    result_t           m_res;

    assign cfg_ready = 1'b1;
    assign stall     = clearing || div_pend_reg || div_busy || div_done;
    assign s_ready   = !stall && res_ready;
    assign accept    = s_valid && s_ready;

    always_comb begin
        col_wrap  = (col_reg >= len_reg);
        col_e     = col_wrap ? '0 : col_reg;
        line_e    = (col_wrap && (line_reg != LINE_W'(MAX_LINES))) ? line_reg + 1'b1
                                                                   : line_reg;
        cur       = !s_flush && s_cell_req && (line_e < lines_reg);
        live_inc  = live_reg + POS_W'(cur);
        trip      = {cur, rd_middle, rd_upper};
        win       = {trip, win_q[0], win_q[1]};

        win_m = win;
        if (oline_reg == '0) begin
            win_m = win_m & ~MASK_TOP;
        end
        if (({1'b0, oline_reg} + 1'b1) >= {1'b0, lines_reg}) begin
            win_m = win_m & ~MASK_BOTTOM;
        end
        if (ocol_reg == '0) begin
            win_m = win_m & ~MASK_LEFT;
        end
        if ((LEN_W'(ocol_reg) + 1'b1) >= len_reg) begin
            win_m = win_m & ~MASK_RIGHT;
        end

        nbr = '0;
        for (int i = 0; i < WIN_W; i++) begin
            if (i != SELF_BIT) begin
                nbr = nbr + CNT_W'(win_m[i]);
            end
        end
        self_live = win_m[SELF_BIT];
        next_cell = self_live ? ((nbr >= SURVIVE_LO) && (nbr <= SURVIVE_HI))
                              : (nbr == BIRTH_N);

        emit       = (line_e >= LINE_W'(2)) || ((line_e == LINE_W'(1)) && (col_e != '0));
        pos_inc    = CMP_W'(opos_reg) + CMP_W'(1);
        last       = (pos_inc >= CMP_W'(total_reg));
        frame_done = accept && emit && last;

        res.next_cell  = next_cell;
        res.frame_end  = last;
        res.live_total = last ? live_inc : '0;
    end

    // next state of the scan counters and configuration
    always_comb begin
        cfg_val32     = 32'(cfg_wdata);
        len_next      = len_reg;
        lines_next    = lines_reg;
        div_pend_next = 1'b0;
        col_next      = col_reg;
        line_next     = line_reg;
        opos_next     = opos_reg;
        oline_next    = oline_reg;
        ocol_next     = ocol_reg;
        live_next     = live_reg;

        if (cfg_valid) begin
            div_pend_next = 1'b1;
            case (cfg_index)
                REG_LINE_LENGTH: begin
                    if (cfg_val32 < 32'(MIN_DIM)) begin
                        len_next = LEN_W'(MIN_DIM);
                    end else if (cfg_val32 > 32'(MAX_LINE)) begin
                        len_next = LEN_W'(MAX_LINE);
                    end else begin
                        len_next = LEN_W'(cfg_val32);
                    end
                end
                REG_LINE_COUNT: begin
                    if (cfg_val32 < 32'(MIN_DIM)) begin
                        lines_next = LINE_W'(MIN_DIM);
                    end else if (cfg_val32 > 32'(MAX_LINES)) begin
                        lines_next = LINE_W'(MAX_LINES);
                    end else begin
                        lines_next = LINE_W'(cfg_val32);
                    end
                end
                default: begin
                    div_pend_next = 1'b0;
                end
            endcase
        end

        if (div_done) begin
            oline_next = div_line;
            ocol_next  = div_col;
        end

        if (accept) begin
            col_next  = col_e + 1'b1;
            line_next = line_e;
            live_next = live_inc;
            if (emit) begin
                if (last) begin
                    col_next   = '0;
                    line_next  = '0;
                    opos_next  = '0;
                    oline_next = '0;
                    ocol_next  = '0;
                    live_next  = '0;
                end else begin
                    opos_next = opos_reg + 1'b1;
                    if ((LEN_W'(ocol_reg) + 1'b1) >= len_reg) begin
                        ocol_next = '0;
                        if (oline_reg != LINE_W'(MAX_LINES)) begin
                            oline_next = oline_reg + 1'b1;
                        end
                    end else begin
                        ocol_next = ocol_reg + 1'b1;
                    end
                end
            end
        end

        // prefetch the column the next item will use
        raddr = (col_next >= len_reg) ? '0 : col_next[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_W'(LEN_RST);
            lines_reg    <= LINE_W'(LIN_RST);
            div_pend_reg <= 1'b0;
            col_reg      <= '0;
            line_reg     <= '0;
            opos_reg     <= '0;
            oline_reg    <= '0;
            ocol_reg     <= '0;
            live_reg     <= '0;
        end else begin
            len_reg      <= len_next;
            lines_reg    <= lines_next;
            div_pend_reg <= div_pend_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            opos_reg     <= opos_next;
            oline_reg    <= oline_next;
            ocol_reg     <= ocol_next;
            live_reg     <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= TOT_W'(len_reg) * TOT_W'(lines_reg);
    end

    // window columns: cell 0 holds the previous column, cell 1 the one before
    for (genvar gi = 0; gi < WIN_COLS; gi++) begin : g_win
        if (gi == 0) begin : g_head
            lgs_win_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (accept),
                .clear   (frame_done),
                .col_in  (trip),
                .col_out (win_q[gi])
            );
        end else begin : g_tail
            lgs_win_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (accept),
                .clear   (frame_done),
                .col_in  (win_q[gi-1]),
                .col_out (win_q[gi])
            );
        end
    end

    lgs_line_store #(
        .DEPTH (MAX_LINE)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .we        (accept),
        .waddr     (col_e[ADDR_W-1:0]),
        .wr_upper  (rd_middle),
        .wr_middle (cur),
        .raddr     (raddr),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle),
        .clearing  (clearing)
    );

    lgs_pos_div #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_pend_reg),
        .dividend  (opos_reg),
        .divisor   (len_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quot_line (div_line),
        .rem_col   (div_col)
    );

    lgs_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && emit),
        .in_data   (res),
        .in_ready  (res_ready),
        .out_valid (m_valid),
        .out_data  (m_res),
        .out_ready (m_ready)
    );

    assign m_next_cell  = m_res.next_cell;
    assign m_frame_end  = m_res.frame_end;
    assign m_live_total = m_res.live_total;

    `LGS_ASSERT_IMPLIES(a_no_accept_in_stall, aclk, aresetn, s_valid && s_ready, !stall)
    `LGS_ASSERT_IMPLIES(a_ocol_in_line, aclk, aresetn, !stall, LEN_W'(ocol_reg) < len_reg)
    `LGS_ASSERT_NEXT(a_frame_clear, aclk, aresetn, frame_done, opos_reg == '0 && col_reg == '0 && live_reg == '0)

endmodule

`default_nettype wire

// ===== design/lgs_win_cell.sv =====
// one column cell of the 3x3 window chain
`default_nettype none

module lgs_win_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      shift,
    input  wire logic                      clear,
    input  wire logic [lgs_pkg::TRIP_W-1:0] col_in,
    output logic      [lgs_pkg::TRIP_W-1:0] col_out
);
    import lgs_pkg::*;

    logic [TRIP_W-1:0] col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (clear) begin
            col_reg <= '0;
        end else if (shift) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ===== design/lgs_line_store.sv =====
// two single-bit line memories with prefetch read and clearing pass after reset
`default_nettype none

module lgs_line_store #(
    parameter int DEPTH = lgs_pkg::DEF_MAX_LINE
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic                     wr_upper,
    input  wire logic                     wr_middle,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic                          rd_upper,
    output logic                          rd_middle,
    output logic                          clearing
);
    import lgs_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLR_W  = $clog2(DEPTH + 1);

    logic upper_mem  [DEPTH];
    logic middle_mem [DEPTH];

    logic [CLR_W-1:0]  clr_cnt_reg;
    logic [ADDR_W-1:0] clr_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wu;
    logic              mem_wm;
    logic              rd_upper_reg;
    logic              rd_middle_reg;

    assign clearing  = (clr_cnt_reg != CLR_W'(DEPTH));
    assign clr_addr  = clr_cnt_reg[ADDR_W-1:0];
    assign mem_we    = clearing || we;
    assign mem_waddr = clearing ? clr_addr : waddr;
    assign mem_wu    = clearing ? 1'b0 : wr_upper;
    assign mem_wm    = clearing ? 1'b0 : wr_middle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            upper_mem[mem_waddr]  <= mem_wu;
            middle_mem[mem_waddr] <= mem_wm;
        end
    end

    // write-first bypass when the prefetch hits the entry being written
    always_ff @(posedge aclk) begin
        if (mem_we && (mem_waddr == raddr)) begin
            rd_upper_reg  <= mem_wu;
            rd_middle_reg <= mem_wm;
        end else begin
            rd_upper_reg  <= upper_mem[raddr];
            rd_middle_reg <= middle_mem[raddr];
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

`default_nettype wire

// ===== design/lgs_pos_div.sv =====
// bit-serial divider that splits the output position into line and column
`default_nettype none

module lgs_pos_div #(
    parameter int MAX_LINE  = lgs_pkg::DEF_MAX_LINE,
    parameter int MAX_LINES = lgs_pkg::DEF_MAX_LINES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [lgs_pkg::POS_W-1:0]       dividend,
    input  wire logic [$clog2(MAX_LINE+1)-1:0]   divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic      [$clog2(MAX_LINES+1)-1:0]  quot_line,
    output logic      [$clog2(MAX_LINE)-1:0]     rem_col
);
    import lgs_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LINE + 1);
    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int STEP_W = $clog2(POS_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [POS_W-1:0]  dq_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  dvs_reg;
    logic [LEN_W:0]    rem_sh;
    logic              q_bit;
    logic [LEN_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, dq_reg[POS_W-1]};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(POS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[POS_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    // any line past the last one behaves the same, so saturate
    assign quot_line = (dq_reg > POS_W'(MAX_LINES)) ? LINE_W'(MAX_LINES)
                                                    : dq_reg[LINE_W-1:0];
    assign rem_col   = rem_reg[ADDR_W-1:0];

endmodule

`default_nettype wire

// ===== design/lgs_out_skid.sv =====
// output register with skid stage for the result channel
`default_nettype none

module lgs_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire lgs_pkg::result_t in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    output lgs_pkg::result_t      out_data,
    input  wire logic             out_ready
);
    import lgs_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take_in;
    logic    to_skid;
    logic    skid_to_out;

    assign in_ready    = !skid_valid_reg;
    assign take_in     = in_valid && !skid_valid_reg;
    assign to_skid     = take_in && out_valid_reg && !out_ready;
    assign skid_to_out = !take_in && out_ready && skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take_in) begin
            if (to_skid) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (to_skid) begin
            skid_data_reg <= in_data;
        end
        if (take_in && !to_skid) begin
            out_data_reg <= in_data;
        end else if (skid_to_out) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
